// File: rtl/nge_pkg.sv
// nge_pkg: shared types, constants and activation functions for the genome evaluator
// no dependencies; imported by nge_ctrl, nge_datapath and neat_genome_evaluator
`default_nettype none

package nge_pkg;

    // table sizes (defaults for top level parameters)
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_CONNS_DEF = 256;

    // fixed by field widths
    localparam int MAX_NODE_ID = 127;
    localparam int ACT_DEPTH   = MAX_NODE_ID + 1;
    localparam int NUM_INPUTS  = 8;
    localparam int NUM_OUTPUTS = 4;
    localparam int ID_W        = 7;
    localparam int LAYER_W     = 17;
    localparam int VAL_W       = 16;
    localparam int OUT_W       = 14;
    localparam int IN_IDX_W    = 3;
    localparam int OUT_IDX_W   = 2;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 16;
    localparam int CFG_DATA_W  = 9;
    localparam int TANH_KNEE   = 78;

    // item kinds on tuser
    localparam logic [1:0] MODE_NODE   = 2'd0;
    localparam logic [1:0] MODE_CONN   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_CONN_COUNT = 1'b1;

    localparam logic [11:0] TANH_MAG [TANH_KNEE] = '{
           0,  256,  509,  759, 1003, 1240, 1468, 1686, 1893, 2088,
        2272, 2443, 2602, 2748, 2883, 3007, 3119, 3223, 3315, 3399,
        3475, 3543, 3604, 3659, 3707, 3751, 3790, 3825, 3856, 3883,
        3908, 3929, 3949, 3966, 3981, 3994, 4006, 4016, 4026, 4034,
        4041, 4048, 4053, 4058, 4063, 4067, 4070, 4073, 4076, 4078,
        4080, 4082, 4084, 4085, 4086, 4088, 4089, 4089, 4090, 4091,
        4091, 4092, 4092, 4093, 4093, 4094, 4094, 4094, 4094, 4095,
        4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAXID,
        S_SEL,
        S_CHECK,
        S_ACC,
        S_FINISH,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_SHOW
    } state_t;

    typedef struct packed {
        logic take;        // input transaction accepted
        logic start;       // clear per-evaluation state
        logic scan_start;  // restart node table scan
        logic scan_run;    // step node table scan
        logic scan_maxid;  // scan finds highest id instead of next node
        logic mark;        // flag picked node as visited
        logic acc_start;   // restart connection scan
        logic acc_run;     // step connection scan
        logic finish;      // store node activation
        logic out_start;
        logic out_read;
        logic out_load;
        logic out_next;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pick_valid;
        logic pick_skip;
        logic acc_done;
        logic out_last;
    } status_t;

    // tanh of table step m, odd in m
    function automatic logic signed [OUT_W-1:0] t_of(input logic signed [7:0] m);
        logic [7:0]              mag;
        logic [12:0]             v;
        logic signed [OUT_W-1:0] t;
        mag = m[7] ? 8'(-m) : 8'(m);
        if (mag < 8'(TANH_KNEE)) begin
            v = {1'b0, TANH_MAG[mag[6:0]]};
        end else begin
            v = 13'd4096;
        end
        t = $signed({1'b0, v});
        return m[7] ? -t : t;
    endfunction

    function automatic logic signed [OUT_W-1:0] tanh_q(input logic signed [VAL_W-1:0] x);
        return t_of($signed(x[15:8]));
    endfunction

    function automatic logic signed [OUT_W-1:0] sigmoid_q(input logic signed [VAL_W-1:0] x);
        logic [7:0]              u;
        logic [8:0]              u1;
        logic signed [7:0]       lo;
        logic signed [7:0]       hi;
        logic signed [OUT_W-1:0] t_lo;
        logic signed [OUT_W-1:0] t_hi;
        logic signed [15:0]      s;
        u    = {~x[15], x[14:8]};
        u1   = {1'b0, u} + 9'd1;
        lo   = $signed({1'b0, u[7:1]}) - 8'sd64;
        hi   = $signed(u1[8:1]) - 8'sd64;
        t_lo = t_of(lo);
        t_hi = t_of(hi);
        s    = 16'sd8192 + {{2{t_lo[OUT_W-1]}}, t_lo} + {{2{t_hi[OUT_W-1]}}, t_hi}
               + 16'sd2;
        return $signed(s[15:2]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/nge_ram.sv
// nge_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module nge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/nge_ctrl.sv
// nge_ctrl: evaluation sequencer of the genome evaluator
// depends on nge_pkg (state, command and status types)
`default_nettype none

module nge_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    input  wire [1:0]         s_tuser,
    input  wire               s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    input  nge_pkg::status_t  st,
    output nge_pkg::cmd_t     cmd
);
    import nge_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && s_tuser == MODE_SAMPLE && s_tlast) begin
                    cmd.start  = 1'b1;
                    state_next = S_MAXID;
                end
            end
            S_MAXID: begin
                cmd.scan_run   = 1'b1;
                cmd.scan_maxid = 1'b1;
                if (st.scan_done) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SEL;
                end
            end
            S_SEL: begin
                cmd.scan_run = 1'b1;
                if (st.scan_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!st.pick_valid) begin
                    cmd.out_start = 1'b1;
                    state_next    = S_OUT_RD;
                end else begin
                    cmd.mark = 1'b1;
                    if (st.pick_skip) begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SEL;
                    end else begin
                        cmd.acc_start = 1'b1;
                        state_next    = S_ACC;
                    end
                end
            end
            S_ACC: begin
                cmd.acc_run = 1'b1;
                if (st.acc_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SEL;
            end
            S_OUT_RD: begin
                cmd.out_read = 1'b1;
                state_next   = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (st.out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.out_next = 1'b1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/nge_datapath.sv
// nge_datapath: genome tables, node and connection scans, accumulator and output register
// depends on nge_pkg and nge_ram
`default_nettype none

module nge_datapath #(
    parameter int MAX_NODES = nge_pkg::MAX_NODES_DEF,
    parameter int MAX_CONNS = nge_pkg::MAX_CONNS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  nge_pkg::cmd_t                     cmd,
    output nge_pkg::status_t                  st,
    input  wire [nge_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire [1:0]                         s_tuser,
    input  wire                               cfg_valid,
    input  wire                               cfg_index,
    input  wire [nge_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [nge_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast
);
    import nge_pkg::*;

    localparam int NA_W  = $clog2(MAX_NODES);
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int CA_W  = $clog2(MAX_CONNS);
    localparam int CC_W  = $clog2(MAX_CONNS + 1);
    localparam int ACC_W = 32 + CC_W;
    localparam int AA_W  = $clog2(ACT_DEPTH);

    // input item fields
    logic [7:0]                f_slot;
    logic [ID_W-1:0]           f_node_id;
    logic [ID_W-1:0]           f_source_id;
    logic [LAYER_W-1:0]        f_layer;
    logic [VAL_W-1:0]          f_weight;
    logic                      f_enabled;
    logic [IN_IDX_W-1:0]       f_in_idx;
    logic [VAL_W-1:0]          f_in_val;

    assign f_slot      = s_tdata[7:0];
    assign f_node_id   = s_tdata[14:8];
    assign f_source_id = s_tdata[21:15];
    assign f_layer     = s_tdata[38:22];
    assign f_weight    = s_tdata[54:39];
    assign f_enabled   = s_tdata[55];
    assign f_in_idx    = s_tdata[58:56];
    assign f_in_val    = s_tdata[74:59];

    // configuration
    logic [6:0]          node_count_reg;
    logic [8:0]          conn_count_reg;
    logic [NC_W-1:0]     nn;
    logic [CC_W-1:0]     nc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
            conn_count_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_NODE_COUNT) begin
                node_count_reg <= cfg_data[6:0];
            end else begin
                conn_count_reg <= cfg_data;
            end
        end
    end

    assign nn = (32'(node_count_reg) > MAX_NODES) ? NC_W'(MAX_NODES) : NC_W'(node_count_reg);
    assign nc = (32'(conn_count_reg) > MAX_CONNS) ? CC_W'(MAX_CONNS) : CC_W'(conn_count_reg);

    // table writes
    logic node_we, conn_we;
    assign node_we = cmd.take && s_tuser == MODE_NODE && 32'(f_slot) < MAX_NODES;
    assign conn_we = cmd.take && s_tuser == MODE_CONN && 32'(f_slot) < MAX_CONNS;

    logic [MAX_CONNS-1:0]   conn_en_reg;
    logic [VAL_W-1:0]       inbuf_reg [NUM_INPUTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_en_reg <= '0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
                inbuf_reg[i] <= '0;
            end
        end else begin
            if (conn_we) begin
                conn_en_reg[CA_W'(f_slot)] <= f_enabled;
            end
            if (cmd.take && s_tuser == MODE_SAMPLE && 32'(f_in_idx) < NUM_INPUTS) begin
                inbuf_reg[f_in_idx] <= f_in_val;
            end
        end
    end

    // node table
    logic [NC_W-1:0]             scan_idx_reg;
    logic [ID_W+LAYER_W-1:0]     node_rdata;
    logic [ID_W-1:0]             nd_id;
    logic [LAYER_W-1:0]          nd_layer;

    nge_ram #(.WIDTH(ID_W + LAYER_W), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (NA_W'(f_slot)),
        .wdata ({f_layer, f_node_id}),
        .raddr (scan_idx_reg[NA_W-1:0]),
        .rdata (node_rdata)
    );

    assign nd_id    = node_rdata[ID_W-1:0];
    assign nd_layer = node_rdata[ID_W+LAYER_W-1:ID_W];

    // connection table
    logic [CC_W-1:0]             conn_idx_reg;
    logic [2*ID_W+VAL_W-1:0]     conn_rdata;
    logic [ID_W-1:0]             c_src;
    logic [ID_W-1:0]             c_dest;
    logic signed [VAL_W-1:0]     c_weight;

    nge_ram #(.WIDTH(2 * ID_W + VAL_W), .DEPTH(MAX_CONNS)) u_conn_ram (
        .aclk  (aclk),
        .we    (conn_we),
        .waddr (CA_W'(f_slot)),
        .wdata ({f_weight, f_source_id, f_node_id}),
        .raddr (conn_idx_reg[CA_W-1:0]),
        .rdata (conn_rdata)
    );

    assign c_dest   = conn_rdata[ID_W-1:0];
    assign c_src    = conn_rdata[2*ID_W-1:ID_W];
    assign c_weight = $signed(conn_rdata[2*ID_W+VAL_W-1:2*ID_W]);

    // activations
    logic                     act_we;
    logic [AA_W-1:0]          act_raddr;
    logic [VAL_W-1:0]         act_rdata;
    logic [VAL_W-1:0]         fin_val;
    logic [OUT_IDX_W-1:0]     out_idx_reg;
    logic [ID_W-1:0]          out_id;
    logic [ID_W-1:0]          pick_id_reg;

    assign out_id    = ID_W'(NUM_INPUTS) + ID_W'(out_idx_reg);
    assign act_raddr = cmd.out_read ? out_id : c_src;
    assign act_we    = cmd.finish;

    nge_ram #(.WIDTH(VAL_W), .DEPTH(ACT_DEPTH)) u_act_ram (
        .aclk  (aclk),
        .we    (act_we),
        .waddr (pick_id_reg),
        .wdata (fin_val),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    // node scan: highest id, then repeated search for the lowest (layer, id)
    logic                    rv_reg;
    logic [NA_W-1:0]         rslot_reg;
    logic [ID_W-1:0]         maxid_reg;
    logic [MAX_NODES-1:0]    done_reg;
    logic [ACT_DEPTH-1:0]    flags_reg;
    logic                    pick_v_reg;
    logic [NA_W-1:0]         pick_slot_reg;
    logic [LAYER_W-1:0]      pick_layer_reg;

    // connection pipeline
    logic                     en1_reg, v1_reg, v2_reg, v3_reg;
    logic                     isin2_reg;
    logic signed [VAL_W-1:0]  inv2_reg;
    logic signed [VAL_W-1:0]  w2_reg;
    logic signed [31:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     hit1;
    logic signed [VAL_W-1:0]  a_op;

    assign hit1 = v1_reg && en1_reg && c_dest == pick_id_reg && c_src <= maxid_reg
                  && (32'(c_src) < NUM_INPUTS || flags_reg[c_src]);
    assign a_op = isin2_reg ? inv2_reg : $signed(act_rdata);

    // output staging
    logic                     oflag_reg;
    logic [OUT_W-1:0]         m_val_reg;
    logic [OUT_IDX_W-1:0]     m_idx_reg;
    logic                     m_last_reg;
    logic signed [VAL_W-1:0]  raw;
    logic signed [OUT_W-1:0]  out_val;

    assign raw     = oflag_reg ? $signed(act_rdata) : '0;
    assign out_val = (out_idx_reg < OUT_IDX_W'(2)) ? tanh_q(raw) : sigmoid_q(raw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rv_reg       <= 1'b0;
            maxid_reg    <= '0;
            done_reg     <= '0;
            flags_reg    <= '0;
            pick_v_reg   <= 1'b0;
            conn_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            out_idx_reg  <= '0;
        end else begin
            if (cmd.start) begin
                maxid_reg    <= '0;
                done_reg     <= '0;
                flags_reg    <= '0;
                scan_idx_reg <= '0;
                rv_reg       <= 1'b0;
            end
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                rv_reg       <= 1'b0;
                pick_v_reg   <= 1'b0;
            end
            if (cmd.scan_run) begin
                if (scan_idx_reg < nn) begin
                    rv_reg       <= 1'b1;
                    rslot_reg    <= scan_idx_reg[NA_W-1:0];
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end else begin
                    rv_reg <= 1'b0;
                end
                if (rv_reg) begin
                    if (cmd.scan_maxid) begin
                        if (nd_id > maxid_reg) begin
                            maxid_reg <= nd_id;
                        end
                    end else if (!done_reg[rslot_reg] && (!pick_v_reg ||
                                 {nd_layer, nd_id} < {pick_layer_reg, pick_id_reg})) begin
                        pick_v_reg     <= 1'b1;
                        pick_slot_reg  <= rslot_reg;
                        pick_layer_reg <= nd_layer;
                        pick_id_reg    <= nd_id;
                    end
                end
            end
            if (cmd.mark) begin
                done_reg[pick_slot_reg] <= 1'b1;
            end
            if (cmd.acc_start) begin
                conn_idx_reg <= '0;
                v1_reg       <= 1'b0;
                v2_reg       <= 1'b0;
                v3_reg       <= 1'b0;
                acc_reg      <= '0;
            end
            if (cmd.acc_run) begin
                if (conn_idx_reg < nc) begin
                    v1_reg       <= 1'b1;
                    en1_reg      <= conn_en_reg[conn_idx_reg[CA_W-1:0]];
                    conn_idx_reg <= conn_idx_reg + 1'b1;
                end else begin
                    v1_reg <= 1'b0;
                end
                v2_reg    <= hit1;
                w2_reg    <= c_weight;
                isin2_reg <= 32'(c_src) < NUM_INPUTS;
                inv2_reg  <= $signed(inbuf_reg[c_src[IN_IDX_W-1:0]]);
                v3_reg    <= v2_reg;
                prod_reg  <= a_op * w2_reg;
                if (v3_reg) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end
            if (cmd.finish) begin
                flags_reg[pick_id_reg] <= 1'b1;
            end
            if (cmd.out_start) begin
                out_idx_reg <= '0;
            end
            if (cmd.out_next) begin
                out_idx_reg <= out_idx_reg + 1'b1;
            end
            if (cmd.out_read) begin
                oflag_reg <= flags_reg[out_id] && out_id <= maxid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_val_reg  <= out_val;
            m_idx_reg  <= out_idx_reg;
            m_last_reg <= out_idx_reg == OUT_IDX_W'(NUM_OUTPUTS - 1);
        end
    end

    // floor to q4.12 and saturate, then tanh for hidden nodes
    logic signed [ACC_W-13:0] q;
    logic                     ovf;
    logic signed [VAL_W-1:0]  sat;
    logic signed [OUT_W-1:0]  th;

    assign q   = $signed(acc_reg[ACC_W-1:12]);
    assign ovf = !(&q[ACC_W-13:15] || ~|q[ACC_W-13:15]);
    assign sat = ovf ? (q[ACC_W-13] ? 16'sh8000 : 16'sh7fff) : q[15:0];
    assign th  = tanh_q(sat);
    assign fin_val = pick_layer_reg[LAYER_W-1] ? sat : {{2{th[OUT_W-1]}}, th};

    assign st.scan_done  = scan_idx_reg >= nn && !rv_reg;
    assign st.pick_valid = pick_v_reg;
    assign st.pick_skip  = 32'(pick_id_reg) < NUM_INPUTS || pick_id_reg > maxid_reg;
    assign st.acc_done   = conn_idx_reg >= nc && !v1_reg && !v2_reg && !v3_reg;
    assign st.out_last   = out_idx_reg == OUT_IDX_W'(NUM_OUTPUTS - 1);

    assign m_tdata = {m_val_reg, m_idx_reg};
    assign m_tlast = m_last_reg;

endmodule

`default_nettype wire

// File: rtl/neat_genome_evaluator.sv
// neat_genome_evaluator: top level of the fixed-point neat network forward pass
// depends on nge_pkg, nge_ctrl, nge_datapath and nge_ram
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata (table writes, samples), s_tuser mode, s_tlast
//  m_       out        m_tvalid / m_tready  m_tdata (output index, value), m_tlast
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data (node_count, conn_count)
//
// table writes and non-final samples are accepted back to back while idle
// an evaluation first scans the node table for the highest id, then for each node
// scans the node table for the next one, plus a connection scan for a node that
// is evaluated (not an input id, not above the highest id), then one last node-table
// scan that finds no node left, all bound by the single read port of the node and
// connection rams, then reads, loads and shows each output, waiting on any output stall
// the block takes no input from a final sample until its last output transaction
// aresetn is synchronous and active low; config is always accepted
`default_nettype none

module neat_genome_evaluator #(
    parameter int MAX_NODES = nge_pkg::MAX_NODES_DEF,
    parameter int MAX_CONNS = nge_pkg::MAX_CONNS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input item stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // slot[7:0] node_id[14:8] source_id[21:15] layer_pos[38:22] weight[54:39]
    // enabled[55] input_index[58:56] input_value[74:59] zero[79:75]
    input  wire [nge_pkg::S_DATA_W-1:0]       s_tdata,
    // mode[1:0]
    input  wire [1:0]                         s_tuser,
    // last_input
    input  wire                               s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // output_index[1:0] output_value[15:2]
    output logic [nge_pkg::M_DATA_W-1:0]      m_tdata,
    // last_output
    output logic                              m_tlast,
    // configuration writes
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire                               cfg_index,
    input  wire [nge_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import nge_pkg::*;

    cmd_t    cmd;
    status_t st;

    // register writes go straight into the configuration registers, no backpressure
    assign cfg_ready = 1'b1;

    // sequencer: idle accepts items, walks node and connection scans, presents outputs
    nge_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // tables, activation store, multiply-accumulate and output register
    nge_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_CONNS (MAX_CONNS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // input and result sides never open together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output both active");

    // a final sample starts an evaluation and closes the input
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_SAMPLE && s_tlast |=> !s_tready)
        else $error("evaluation did not start");

    // the last output transaction returns the block to idle
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after last output");
`endif

endmodule

`default_nettype wire
